/* design/lkvs_pkg.sv */
// ----------------------------------------------------------------------------
// lkvs_pkg
// Shared constants, request codes and controller command type for the
// lru key-value store.
// ----------------------------------------------------------------------------
package lkvs_pkg;

	// default geometry
	localparam int DEPTH_DEF       = 16;
	localparam int KEY_WIDTH_DEF   = 32;
	localparam int VALUE_WIDTH_DEF = 32;

	// request codes
	localparam int ACTION_W = 2;
	localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ERASE  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd2;

	// configuration register file
	localparam int CFG_W   = 5;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic                  REG_CAPACITY   = 1'b0;
	localparam logic [CFG_W-1:0]      CAPACITY_RESET = 5'd16;

	// controller to datapath commands
	typedef struct packed {
		logic load;    // latch request and clear scan trackers
		logic rd;      // read slot memories at the scan address
		logic commit;  // apply the update and present the result
	} lkvs_cmd_t;

endpackage

/* design/lkvs_ctrl.sv */
// ----------------------------------------------------------------------------
// lkvs_ctrl
// Request sequencer: accepts a transaction, walks the slot scan address over
// every slot, drains the compare stage and issues the commit.
// ----------------------------------------------------------------------------
module lkvs_ctrl #(
	parameter int DEPTH = lkvs_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	output lkvs_pkg::lkvs_cmd_t      cmd,
	output logic [$clog2(DEPTH)-1:0] addr
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_LAST = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   addr_q;

	// state and scan address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			addr_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					addr_q <= '0;
					if (start) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (addr_q == LAST_IDX) begin
						state_q <= S_LAST;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_LAST: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && start;
		cmd.rd     = (state_q == S_SCAN);
		cmd.commit = (state_q == S_DONE);
	end

	assign busy = (state_q != S_IDLE);
	assign addr = addr_q;

endmodule

/* design/lkvs_datapath.sv */
// ----------------------------------------------------------------------------
// lkvs_datapath
// Slot storage, recency ranks, scan compare stage and result registers.
// Keys and values sit in memories with one read port and one write port, read one slot per cycle.
// ----------------------------------------------------------------------------
module lkvs_datapath #(
	parameter int DEPTH       = lkvs_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH   = lkvs_pkg::KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = lkvs_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkvs_pkg::lkvs_cmd_t           cmd,
	input  logic [$clog2(DEPTH)-1:0]      addr,
	input  logic [lkvs_pkg::CFG_W-1:0]    capacity,
	input  logic [lkvs_pkg::ACTION_W-1:0] action,
	input  logic [KEY_WIDTH-1:0]          key,
	input  logic [VALUE_WIDTH-1:0]        value,
	output logic                          done,
	output logic                          hit,
	output logic [VALUE_WIDTH-1:0]        value_out,
	output logic                          evicted,
	output logic [KEY_WIDTH-1:0]          evicted_key
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int AGE_W = IDX_W;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > lkvs_pkg::CFG_W) ? CNT_W : lkvs_pkg::CFG_W;

	// slot state
	logic                   valid_q [DEPTH];
	logic [AGE_W-1:0]       age_q   [DEPTH];
	logic [CNT_W-1:0]       live_q;
	logic [KEY_WIDTH-1:0]   key_mem [DEPTH];
	logic [VALUE_WIDTH-1:0] val_mem [DEPTH];

	// latched request
	logic [lkvs_pkg::ACTION_W-1:0] act_q;
	logic [KEY_WIDTH-1:0]          req_key_q;
	logic [VALUE_WIDTH-1:0]        req_val_q;

	// compare stage
	logic                   cmp_vld_s1;
	logic [IDX_W-1:0]       cmp_idx_s1;
	logic [KEY_WIDTH-1:0]   rd_key_s1;
	logic [VALUE_WIDTH-1:0] rd_val_s1;

	// scan trackers
	logic                   hit_fnd_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic [AGE_W-1:0]       hit_age_q;
	logic [VALUE_WIDTH-1:0] hit_val_q;
	logic                   free_fnd_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic                   old_fnd_q;
	logic [IDX_W-1:0]       old_idx_q;
	logic [AGE_W-1:0]       old_age_q;
	logic [KEY_WIDTH-1:0]   old_key_q;

	// result registers
	logic                   done_q;
	logic                   hit_q;
	logic [VALUE_WIDTH-1:0] value_out_q;
	logic                   evicted_q;
	logic [KEY_WIDTH-1:0]   evicted_key_q;

	logic                   cur_valid;
	logic [AGE_W-1:0]       cur_age;
	logic                   key_match;
	logic [CMP_W-1:0]       cap_ext;
	logic [CMP_W-1:0]       live_ext;
	logic                   room;
	logic                   op_touch;
	logic                   op_release;
	logic                   op_fill;
	logic                   op_evict;
	logic [IDX_W-1:0]       tgt_idx;
	logic [AGE_W-1:0]       tgt_age;
	logic                   act_known;

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q     <= action;
			req_key_q <= key;
			req_val_q <= value;
		end
	end

	// slot memory read port and write port
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_key_s1 <= key_mem[addr];
			rd_val_s1 <= val_mem[addr];
		end
		if (cmd.commit && (op_fill || op_evict)) begin
			key_mem[tgt_idx] <= req_key_q;
			val_mem[tgt_idx] <= req_val_q;
		end
	end

	// compare stage index follows the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			cmp_vld_s1 <= cmd.rd;
			cmp_idx_s1 <= addr;
		end
	end

	assign cur_valid = valid_q[cmp_idx_s1];
	assign cur_age   = age_q[cmp_idx_s1];
	assign key_match = cur_valid && (rd_key_s1 == req_key_q);

	// first match, first free slot, oldest live slot (lowest index on a tie)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_fnd_q  <= 1'b0;
			hit_idx_q  <= '0;
			hit_age_q  <= '0;
			hit_val_q  <= '0;
			free_fnd_q <= 1'b0;
			free_idx_q <= '0;
			old_fnd_q  <= 1'b0;
			old_idx_q  <= '0;
			old_age_q  <= '0;
			old_key_q  <= '0;
		end else if (cmd.load) begin
			hit_fnd_q  <= 1'b0;
			free_fnd_q <= 1'b0;
			old_fnd_q  <= 1'b0;
		end else if (cmp_vld_s1) begin
			if (key_match && !hit_fnd_q) begin
				hit_fnd_q <= 1'b1;
				hit_idx_q <= cmp_idx_s1;
				hit_age_q <= cur_age;
				hit_val_q <= rd_val_s1;
			end
			if (!cur_valid && !free_fnd_q) begin
				free_fnd_q <= 1'b1;
				free_idx_q <= cmp_idx_s1;
			end
			if (cur_valid && (!old_fnd_q || (cur_age > old_age_q))) begin
				old_fnd_q <= 1'b1;
				old_idx_q <= cmp_idx_s1;
				old_age_q <= cur_age;
				old_key_q <= rd_key_s1;
			end
		end
	end

	// room below the effective capacity (zero reads as one, clipped to depth)
	always_comb begin
		cap_ext  = CMP_W'(capacity);
		live_ext = CMP_W'(live_q);
		if (cap_ext == '0) begin
			room = (live_ext < CMP_W'(1));
		end else if (cap_ext > CMP_W'(DEPTH)) begin
			room = (live_ext < CMP_W'(DEPTH));
		end else begin
			room = (live_ext < cap_ext);
		end
	end

	// commit decode
	always_comb begin
		op_touch   = 1'b0;
		op_release = 1'b0;
		op_fill    = 1'b0;
		op_evict   = 1'b0;
		tgt_idx    = hit_idx_q;
		tgt_age    = hit_age_q;
		act_known  = 1'b1;
		case (act_q)
			lkvs_pkg::ACT_FIND: begin
				op_touch = hit_fnd_q;
			end
			lkvs_pkg::ACT_ERASE: begin
				op_release = hit_fnd_q;
			end
			lkvs_pkg::ACT_INSERT: begin
				if (hit_fnd_q) begin
					op_touch = 1'b1;
				end else if (room && free_fnd_q) begin
					op_fill = 1'b1;
					tgt_idx = free_idx_q;
				end else if (old_fnd_q) begin
					op_evict = 1'b1;
					tgt_idx  = old_idx_q;
					tgt_age  = old_age_q;
				end else begin
					op_fill = 1'b1;
					tgt_idx = '0;
				end
			end
			default: begin
				act_known = 1'b0;
			end
		endcase
	end

	// recency ranks and valid bits, each slot updated on its own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				valid_q[i] <= 1'b0;
				age_q[i]   <= '0;
			end
		end else if (cmd.commit) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (tgt_idx == IDX_W'(i)) begin
					if (op_touch) begin
						age_q[i] <= '0;
					end else if (op_release) begin
						valid_q[i] <= 1'b0;
						age_q[i]   <= '0;
					end else if (op_fill || op_evict) begin
						valid_q[i] <= 1'b1;
						age_q[i]   <= '0;
					end
				end else if (valid_q[i]) begin
					if (op_touch && (age_q[i] < tgt_age)) begin
						age_q[i] <= age_q[i] + 1'b1;
					end else if (op_release && (age_q[i] > tgt_age)) begin
						age_q[i] <= age_q[i] - 1'b1;
					end else if (op_fill) begin
						age_q[i] <= age_q[i] + 1'b1;
					end else if (op_evict && !(age_q[i] > tgt_age)) begin
						age_q[i] <= age_q[i] + 1'b1;
					end
				end
			end
		end
	end

	// live entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else if (cmd.commit) begin
			if (op_release && (live_q != '0)) begin
				live_q <= live_q - 1'b1;
			end else if (op_fill) begin
				live_q <= live_q + 1'b1;
			end
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q         <= hit_fnd_q && act_known;
			value_out_q   <= ((act_q == lkvs_pkg::ACT_FIND) && hit_fnd_q) ? hit_val_q : '0;
			evicted_q     <= op_evict;
			evicted_key_q <= op_evict ? old_key_q : '0;
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign value_out   = value_out_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

endmodule

/* design/lru_key_value_store_core.sv */
// done strobes a result after start is taken, every slot is scanned and the commit is registered.
// One transaction at a time: busy is high while it runs, and start is taken only while idle.
// The key scan reads one slot per cycle through the single slot memory read port.
// done is high for exactly one cycle and cannot be stalled by the receiver.
// Reset (arst_n low, asynchronous): store empty, all ranks zero, capacity 16.
// ----------------------------------------------------------------------------
// lru_key_value_store_core
// Bounded key-value store with least-recently-used replacement: find, erase
// and insert requests, plus an apb-style capacity register.
// ----------------------------------------------------------------------------
module lru_key_value_store_core #(
	parameter int DEPTH       = lkvs_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH   = lkvs_pkg::KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = lkvs_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lkvs_pkg::PADDR_W-1:0]  paddr,
	input  logic [lkvs_pkg::PDATA_W-1:0]  pwdata,
	output logic [lkvs_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	// request
	input  logic                          start,
	output logic                          busy,
	input  logic [lkvs_pkg::ACTION_W-1:0] action,
	input  logic [KEY_WIDTH-1:0]          key,
	input  logic [VALUE_WIDTH-1:0]        value,
	// result
	output logic                          done,
	output logic                          hit,
	output logic [VALUE_WIDTH-1:0]        value_out,
	output logic                          evicted,
	output logic [KEY_WIDTH-1:0]          evicted_key
);

	localparam int IDX_W = $clog2(DEPTH);

	logic [lkvs_pkg::CFG_W-1:0] capacity_q;
	lkvs_pkg::lkvs_cmd_t        cmd;
	logic [IDX_W-1:0]           scan_addr;
	logic                       reg_sel;

	assign reg_sel = (paddr[2] == lkvs_pkg::REG_CAPACITY);
	assign pready  = 1'b1;

	// capacity register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkvs_pkg::CAPACITY_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			capacity_q <= pwdata[lkvs_pkg::CFG_W-1:0];
		end
	end

	// register read back
	assign prdata = reg_sel ? lkvs_pkg::PDATA_W'(capacity_q) : '0;

	lkvs_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.addr   (scan_addr)
	);

	lkvs_datapath #(
		.DEPTH       (DEPTH),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.addr        (scan_addr),
		.capacity    (capacity_q),
		.action      (action),
		.key         (key),
		.value       (value),
		.done        (done),
		.hit         (hit),
		.value_out   (value_out),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

endmodule
